// ----- rtl/core/nls_pkg.sv -----
package nls_pkg;

    localparam logic [7:0] SEP_RESET = 8'd95;

    localparam logic [1:0] KIND_INT     = 2'd0;
    localparam logic [1:0] KIND_FLOAT   = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    typedef struct packed {
        logic dec;
        logic hex;
        logic bin;
        logic idc;
        logic ids;
        logic sep;
        logic zero;
        logic dot;
        logic x;
        logic b;
        logic e;
        logic sign;
        logic iu;
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic        start;
    } queue_entry_t;

    // end of text matches no class
    function automatic char_class_t classify(input logic [7:0] ch, input logic eot,
                                             input logic [7:0] sep);
        char_class_t c;
        logic        alpha;
        alpha  = ch inside {["a":"z"], ["A":"Z"]};
        c.dec  = ch inside {["0":"9"]};
        c.hex  = c.dec || (ch inside {["a":"f"], ["A":"F"]});
        c.bin  = ch inside {"0", "1"};
        c.idc  = alpha || c.dec || (ch == "_");
        c.ids  = alpha || (ch == "_");
        c.sep  = ch == sep;
        c.zero = ch == "0";
        c.dot  = ch == ".";
        c.x    = ch inside {"x", "X"};
        c.b    = ch inside {"b", "B"};
        c.e    = ch inside {"e", "E"};
        c.sign = ch inside {"+", "-"};
        c.iu   = ch inside {"i", "u"};
        if (eot)
        begin
            c = '0;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/nls_in_if.sv -----
interface nls_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       start_of_literal;
    logic       end_of_text;

    modport source (output valid, output ch, output start_of_literal, output end_of_text,
                    input ready);
    modport sink (input valid, input ch, input start_of_literal, input end_of_text,
                  output ready);
endinterface

// ----- rtl/core/nls_out_if.sv -----
interface nls_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] token_kind;
    logic [7:0] token_length;

    modport source (output valid, output token_kind, output token_length, input ready);
    modport sink (input valid, input token_kind, input token_length, output ready);
endinterface

// ----- rtl/core/numeric_literal_scanner.sv -----
// the back end registers a token when it pops the character that ends it from the queue
// throughput: one character per cycle unless output stalls, set by the one-step back end
// a two-entry queue lets the front keep taking characters while a token waits
// reset: asynchronous, active low; scanner goes idle, separator returns to underscore
// no clearing pass after reset
module numeric_literal_scanner #(
    parameter int MAX_LENGTH = 255
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [7:0] cfg_data,
    nls_in_if.sink     chars,
    nls_out_if.source  tokens
);

    logic                  pop;
    logic                  q_valid;
    nls_pkg::queue_entry_t q_entry;

    nls_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .chars     (chars),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_entry   (q_entry)
    );

    nls_back #(
        .MAX_LENGTH (MAX_LENGTH)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .pop     (pop),
        .tokens  (tokens)
    );

endmodule

// ----- rtl/core/nls_front.sv -----
module nls_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [7:0]            cfg_data,
    nls_in_if.sink                chars,
    input  logic                  pop,
    output logic                  q_valid,
    output nls_pkg::queue_entry_t q_entry
);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int FW     = $clog2(QDEPTH + 1);

    logic [7:0]            sep_reg;
    nls_pkg::queue_entry_t entry_reg [QDEPTH];
    logic [QAW-1:0]        wr_ptr_reg;
    logic [QAW-1:0]        rd_ptr_reg;
    logic [FW-1:0]         fill_reg;
    logic [FW-1:0]         fill_next;
    logic                  push;
    nls_pkg::queue_entry_t new_entry;

    assign chars.ready = fill_reg != FW'(QDEPTH);
    assign push        = chars.valid && chars.ready;
    assign q_valid     = fill_reg != '0;
    assign q_entry     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        new_entry.cls   = nls_pkg::classify(chars.ch, chars.end_of_text, sep_reg);
        new_entry.start = chars.start_of_literal;
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + FW'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg    <= nls_pkg::SEP_RESET;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                sep_reg <= cfg_data;
            end
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QAW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QAW'(1);
            end
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

// ----- rtl/core/nls_back.sv -----
module nls_back #(
    parameter int MAX_LENGTH = 255
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  nls_pkg::queue_entry_t q_entry,
    output logic                  pop,
    nls_out_if.source             tokens
);

    localparam int CNT_W = $clog2(MAX_LENGTH + 1);
    localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;

    localparam logic [3:0] M_IDLE   = 4'd0;
    localparam logic [3:0] M_ZERO   = 4'd1;
    localparam logic [3:0] M_INT    = 4'd2;
    localparam logic [3:0] M_HEX    = 4'd3;
    localparam logic [3:0] M_BIN    = 4'd4;
    localparam logic [3:0] M_DOT    = 4'd5;
    localparam logic [3:0] M_FRAC   = 4'd6;
    localparam logic [3:0] M_EPEND  = 4'd7;
    localparam logic [3:0] M_EXP    = 4'd8;
    localparam logic [3:0] M_SUFFIX = 4'd9;
    localparam logic [3:0] M_THEX   = 4'd10;
    localparam logic [3:0] M_TBIN   = 4'd11;

    logic [3:0]       mode_reg,  mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             err_reg,   err_next;
    logic             ldig_reg,  ldig_next;
    logic             lsep_reg,  lsep_next;
    logic             rhd_reg,   rhd_next;
    logic             flt_reg,   flt_next;
    logic             out_valid_reg;
    logic [1:0]       kind_reg,  kind_next;
    logic [7:0]       len_reg,   len_next;
    logic             ended;
    logic             emit;
    logic [EXT_W-1:0] cnt_ext;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_W'(MAX_LENGTH)) ? c + CNT_W'(1) : c;
    endfunction

    assign pop                 = q_valid && (!out_valid_reg || tokens.ready);
    assign emit                = pop && ended;
    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = kind_reg;
    assign tokens.token_length = len_reg;

    always_comb
    begin
        nls_pkg::char_class_t c;
        logic [3:0]           m;
        logic [CNT_W-1:0]     cnt;
        logic                 err;
        logic                 ld;
        logic                 ls;
        logic                 rh;
        logic                 flt;
        logic                 dig;
        logic                 took;
        c     = q_entry.cls;
        m     = mode_reg;
        cnt   = count_reg;
        err   = err_reg;
        ld    = ldig_reg;
        ls    = lsep_reg;
        rh    = rhd_reg;
        flt   = flt_reg;
        ended = 1'b0;
        took  = 1'b0;
        dig   = 1'b0;
        if (q_entry.start)
        begin
            m   = M_INT;
            cnt = '0;
            err = 1'b0;
            flt = 1'b0;
            ld  = 1'b0;
            ls  = 1'b0;
            rh  = 1'b0;
            if (c.zero)
            begin
                m   = M_ZERO;
                cnt = CNT_W'(1);
            end
            else if (c.dot)
            begin
                m   = M_FRAC;
                cnt = CNT_W'(1);
                flt = 1'b1;
            end
        end
        if (!(q_entry.start && (c.zero || c.dot)))
        begin
            // zero not followed by a radix letter is a decimal digit
            if (m == M_ZERO && !(c.x || c.b))
            begin
                m  = M_INT;
                ld = 1'b1;
                rh = 1'b1;
            end
            if (m == M_HEX || m == M_THEX)
            begin
                dig = c.hex;
            end
            else if (m == M_BIN || m == M_TBIN)
            begin
                dig = c.bin;
            end
            else
            begin
                dig = c.dec;
            end
            // digit run bookkeeping
            if (m inside {M_INT, M_FRAC, M_EXP, M_HEX, M_BIN})
            begin
                if (dig)
                begin
                    ld   = 1'b1;
                    ls   = 1'b0;
                    rh   = 1'b1;
                    cnt  = sat_inc(cnt);
                    took = 1'b1;
                end
                else if (c.sep)
                begin
                    if (!ld)
                    begin
                        err = 1'b1;
                    end
                    ld   = 1'b0;
                    ls   = 1'b1;
                    cnt  = sat_inc(cnt);
                    took = 1'b1;
                end
                else if (ls || !rh)
                begin
                    err = 1'b1;
                end
            end
            case (m)
                M_IDLE:
                begin
                end
                M_ZERO:
                begin
                    cnt = sat_inc(cnt);
                    ld  = 1'b0;
                    ls  = 1'b0;
                    rh  = 1'b0;
                    m   = c.x ? M_HEX : M_BIN;
                end
                M_INT, M_FRAC:
                begin
                    if (!took)
                    begin
                        if (m == M_INT && c.dot)
                        begin
                            m = M_DOT;
                        end
                        else if (c.e)
                        begin
                            m = M_EPEND;
                        end
                        else if (c.ids)
                        begin
                            cnt = sat_inc(cnt);
                            m   = M_SUFFIX;
                        end
                        else
                        begin
                            ended = 1'b1;
                        end
                    end
                end
                M_DOT:
                begin
                    if (c.dec)
                    begin
                        cnt = sat_inc(sat_inc(cnt));
                        flt = 1'b1;
                        ld  = 1'b1;
                        ls  = 1'b0;
                        rh  = 1'b1;
                        m   = M_FRAC;
                    end
                    else if (c.dot || c.idc)
                    begin
                        ended = 1'b1;
                    end
                    else
                    begin
                        cnt   = sat_inc(cnt);
                        flt   = 1'b1;
                        ended = 1'b1;
                    end
                end
                M_EPEND:
                begin
                    if (c.dec || c.sign)
                    begin
                        cnt = sat_inc(sat_inc(cnt));
                        flt = 1'b1;
                        ld  = c.dec;
                        ls  = 1'b0;
                        rh  = c.dec;
                        m   = M_EXP;
                    end
                    else if (!c.sep && c.idc)
                    begin
                        cnt = sat_inc(sat_inc(cnt));
                        m   = M_SUFFIX;
                    end
                    else if (c.sep)
                    begin
                        cnt = sat_inc(sat_inc(cnt));
                        flt = 1'b1;
                        err = 1'b1;
                        ld  = 1'b0;
                        ls  = 1'b1;
                        rh  = 1'b0;
                        m   = M_EXP;
                    end
                    else
                    begin
                        cnt   = sat_inc(cnt);
                        flt   = 1'b1;
                        err   = 1'b1;
                        ended = 1'b1;
                    end
                end
                M_EXP:
                begin
                    if (!took)
                    begin
                        if (c.ids)
                        begin
                            cnt = sat_inc(cnt);
                            m   = M_SUFFIX;
                        end
                        else
                        begin
                            ended = 1'b1;
                        end
                    end
                end
                M_SUFFIX:
                begin
                    if (c.idc)
                    begin
                        cnt = sat_inc(cnt);
                    end
                    else
                    begin
                        ended = 1'b1;
                    end
                end
                M_HEX, M_BIN:
                begin
                    if (!took)
                    begin
                        if (c.iu)
                        begin
                            cnt = sat_inc(cnt);
                            m   = M_SUFFIX;
                        end
                        else if (c.idc)
                        begin
                            err = 1'b1;
                            cnt = sat_inc(cnt);
                            m   = (m == M_HEX) ? M_THEX : M_TBIN;
                        end
                        else
                        begin
                            ended = 1'b1;
                        end
                    end
                end
                M_THEX, M_TBIN:
                begin
                    if (c.sep || c.idc)
                    begin
                        if (!c.sep && !dig)
                        begin
                            err = 1'b1;
                        end
                        cnt = sat_inc(cnt);
                    end
                    else
                    begin
                        ended = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        cnt_ext   = EXT_W'(cnt);
        len_next  = (cnt_ext > EXT_W'(255)) ? 8'd255 : cnt_ext[7:0];
        kind_next = err ? nls_pkg::KIND_INVALID
                  : (flt ? nls_pkg::KIND_FLOAT : nls_pkg::KIND_INT);
        if (ended)
        begin
            m   = M_IDLE;
            cnt = '0;
            err = 1'b0;
            flt = 1'b0;
            ld  = 1'b0;
            ls  = 1'b0;
            rh  = 1'b0;
        end
        mode_next  = m;
        count_next = cnt;
        err_next   = err;
        ldig_next  = ld;
        lsep_next  = ls;
        rhd_next   = rh;
        flt_next   = flt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_IDLE;
            count_reg     <= '0;
            err_reg       <= 1'b0;
            ldig_reg      <= 1'b0;
            lsep_reg      <= 1'b0;
            rhd_reg       <= 1'b0;
            flt_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                err_reg   <= err_next;
                ldig_reg  <= ldig_next;
                lsep_reg  <= lsep_next;
                rhd_reg   <= rhd_next;
                flt_reg   <= flt_next;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (tokens.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            len_reg  <= len_next;
        end
    end

`ifndef SYNTHESIS
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !tokens.ready) |-> !pop)
        else $error("queue popped while result register blocked");
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (mode_reg == M_IDLE && count_reg == '0))
        else $error("scanner not cleared after token");
    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == M_IDLE) |-> (count_reg == '0 && !err_reg && !flt_reg))
        else $error("idle scanner holds literal state");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LENGTH))
        else $error("length count above maximum");
`endif

endmodule

// ----- tb/numeric_literal_scanner_test.sv -----
`timescale 1ns / 1ps

typedef enum logic [3:0] {
    ST_IDLE, ST_ZERO, ST_INT, ST_HEX, ST_BIN, ST_DOT, ST_FRAC, ST_EPEND, ST_EXP,
    ST_SUFFIX, ST_THEX, ST_TBIN
} scan_state_e;

typedef enum logic [1:0] {BASE_DEC, BASE_HEX, BASE_BIN} digit_base_e;

typedef struct packed {
    logic [1:0] kind;
    logic [7:0] length;
} token_t;

class token_scoreboard;
    localparam int MAX_LEN = 255;

    logic [7:0]  separator;
    scan_state_e state;
    int unsigned count;
    bit          bad;
    bit          prev_digit;
    bit          prev_sep;
    bit          run_digit;
    bit          fractional;
    token_t      expected_tokens[$];
    int          errors;

    function new();
        separator = nls_pkg::SEP_RESET;
        errors = 0;
        clear();
    endfunction

    function int pending();
        return expected_tokens.size();
    endfunction

    function void open_run();
        prev_digit = 0;
        prev_sep = 0;
        run_digit = 0;
    endfunction

    function void clear();
        state = ST_IDLE;
        count = 0;
        bad = 0;
        fractional = 0;
        open_run();
    endfunction

    // a negative symbol stands for end of text and matches nothing
    function bit is_dec(int c);
        if (c < 0)
            return 0;
        return c >= "0" && c <= "9";
    endfunction

    function bit is_alpha(int c);
        if (c < 0)
            return 0;
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function bit is_ids(int c);
        return is_alpha(c) || c == "_";
    endfunction

    function bit is_idc(int c);
        return is_ids(c) || is_dec(c);
    endfunction

    function bit is_sep(int c);
        return c >= 0 && c == int'(separator);
    endfunction

    function bit is_base_digit(digit_base_e base, int c);
        if (base == BASE_HEX)
            return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        if (base == BASE_BIN)
            return c == "0" || c == "1";
        return is_dec(c);
    endfunction

    function void bump();
        if (count < MAX_LEN)
            count++;
    endfunction

    function bit take_run(int s, digit_base_e base);
        if (is_base_digit(base, s))
        begin
            prev_digit = 1;
            prev_sep = 0;
            run_digit = 1;
            bump();
            return 1;
        end
        if (is_sep(s))
        begin
            if (!prev_digit)
                bad = 1;
            prev_digit = 0;
            prev_sep = 1;
            bump();
            return 1;
        end
        if (prev_sep || !run_digit)
            bad = 1;
        return 0;
    endfunction

    function bit suffix_or_end(int s);
        if (is_ids(s))
        begin
            bump();
            state = ST_SUFFIX;
            return 0;
        end
        return 1;
    endfunction

    function bit exp_or_suffix(int s);
        if (s == "e" || s == "E")
        begin
            state = ST_EPEND;
            return 0;
        end
        return suffix_or_end(s);
    endfunction

    // returns 1 when the symbol ends the literal
    function bit advance(int s);
        digit_base_e base;
        while (1)
        begin
            case (state)
                ST_ZERO:
                begin
                    if (s == "x" || s == "X" || s == "b" || s == "B")
                    begin
                        bump();
                        open_run();
                        state = (s == "x" || s == "X") ? ST_HEX : ST_BIN;
                        return 0;
                    end
                    state = ST_INT;
                    prev_digit = 1;
                    run_digit = 1;
                end
                ST_INT:
                begin
                    if (take_run(s, BASE_DEC))
                        return 0;
                    if (s == ".")
                    begin
                        state = ST_DOT;
                        return 0;
                    end
                    return exp_or_suffix(s);
                end
                ST_DOT:
                begin
                    if (is_dec(s))
                    begin
                        bump();
                        fractional = 1;
                        open_run();
                        state = ST_FRAC;
                        continue;
                    end
                    if (s == "." || is_idc(s))
                        return 1;
                    bump();
                    fractional = 1;
                    return 1;
                end
                ST_FRAC:
                begin
                    if (take_run(s, BASE_DEC))
                        return 0;
                    return exp_or_suffix(s);
                end
                ST_EPEND:
                begin
                    if (is_dec(s) || s == "+" || s == "-")
                    begin
                        bump();
                        fractional = 1;
                        open_run();
                        state = ST_EXP;
                        if (!is_dec(s))
                        begin
                            bump();
                            return 0;
                        end
                        continue;
                    end
                    if (!is_sep(s) && is_idc(s))
                    begin
                        bump();
                        state = ST_SUFFIX;
                        continue;
                    end
                    bump();
                    fractional = 1;
                    open_run();
                    state = ST_EXP;
                end
                ST_EXP:
                begin
                    if (take_run(s, BASE_DEC))
                        return 0;
                    return suffix_or_end(s);
                end
                ST_SUFFIX:
                begin
                    if (is_idc(s))
                    begin
                        bump();
                        return 0;
                    end
                    return 1;
                end
                ST_HEX, ST_BIN:
                begin
                    base = (state == ST_HEX) ? BASE_HEX : BASE_BIN;
                    if (take_run(s, base))
                        return 0;
                    if (s == "i" || s == "u")
                    begin
                        bump();
                        state = ST_SUFFIX;
                        return 0;
                    end
                    if (is_sep(s) || is_idc(s))
                    begin
                        state = (base == BASE_HEX) ? ST_THEX : ST_TBIN;
                        continue;
                    end
                    return 1;
                end
                ST_THEX, ST_TBIN:
                begin
                    base = (state == ST_THEX) ? BASE_HEX : BASE_BIN;
                    if (!(is_sep(s) || is_idc(s)))
                        return 1;
                    if (!is_sep(s) && !is_base_digit(base, s))
                        bad = 1;
                    bump();
                    return 0;
                end
                default:
                    return 0;
            endcase
        end
    endfunction

    function void note_char(logic [7:0] ch, logic start, logic eot);
        int     s;
        token_t t;
        s = eot ? -1 : int'(ch);
        if (start)
        begin
            clear();
            if (s == "0")
            begin
                count = 1;
                state = ST_ZERO;
                return;
            end
            if (s == ".")
            begin
                count = 1;
                fractional = 1;
                state = ST_FRAC;
                return;
            end
            state = ST_INT;
        end
        if (state == ST_IDLE)
            return;
        if (!advance(s))
            return;
        t.kind = bad ? nls_pkg::KIND_INVALID : (fractional ? nls_pkg::KIND_FLOAT : nls_pkg::KIND_INT);
        t.length = (count > 255) ? 8'd255 : 8'(count);
        expected_tokens.push_back(t);
        clear();
    endfunction

    function void check_token(logic [1:0] kind, logic [7:0] length);
        token_t want;
        if (expected_tokens.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected token, expected none, actual kind %0d length %0d",
                     $time, kind, length);
            return;
        end
        want = expected_tokens.pop_front();
        if (kind !== want.kind)
        begin
            errors++;
            $display("%0t: token kind expected %0d, actual %0d", $time, want.kind, kind);
        end
        if (length !== want.length)
        begin
            errors++;
            $display("%0t: token length expected %0d, actual %0d", $time, want.length, length);
        end
    endfunction
endclass

module numeric_literal_scanner_test;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 250;
    localparam logic [7:0] SEP_PLAN [PHASES] = '{8'd95, 8'd0, 8'd255, "0", ".", "e", "x", "_"};

    logic            clk;
    logic            rst_n;
    logic            cfg_write;
    logic [7:0]      cfg_data;
    bit              no_gaps = 0;
    int              quiet_cycles = 0;
    token_scoreboard tokens_sb;

    nls_in_if  chars_bus ();
    nls_out_if tokens_bus ();

    numeric_literal_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .chars     (chars_bus),
        .tokens    (tokens_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic void append_run(ref logic [7:0] text[$], input digit_base_e base,
                                       input int n, input logic [7:0] sep);
        string hex_digits;
        hex_digits = "0123456789abcdefABCDEF";
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                text.push_back(sep);
            else if (base == BASE_HEX)
                text.push_back(hex_digits[$urandom_range(0, 21)]);
            else if (base == BASE_BIN)
                text.push_back(8'("0" + $urandom_range(0, 1)));
            else
                text.push_back(8'("0" + $urandom_range(0, 9)));
        end
    endfunction

    function automatic void append_ident(ref logic [7:0] text[$], input int n);
        string id_chars;
        id_chars = "abcxyzEeiuQ_09";
        for (int i = 0; i < n; i++)
            text.push_back(id_chars[$urandom_range(0, id_chars.len() - 1)]);
    endfunction

    task automatic send_char(input logic [7:0] c, input logic start, input logic eot);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            chars_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        chars_bus.valid <= 1'b1;
        chars_bus.ch <= c;
        chars_bus.start_of_literal <= start;
        chars_bus.end_of_text <= eot;
        @(posedge clk);
        while (!chars_bus.ready)
            @(posedge clk);
        tokens_sb.note_char(c, start, eot);
    endtask

    task automatic send_word(input string w);
        for (int i = 0; i < w.len(); i++)
            send_char(w[i], i == 0, 1'b0);
    endtask

    task automatic wait_drained();
        chars_bus.valid <= 1'b0;
        while (tokens_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((chars_bus.valid && chars_bus.ready) || (tokens_bus.valid && tokens_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : token_sink
        int stall;
        stall = 0;
        tokens_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (tokens_bus.valid && tokens_bus.ready)
                tokens_sb.check_token(tokens_bus.token_kind, tokens_bus.token_length);
            if (stall > 0)
            begin
                tokens_bus.ready <= 1'b0;
                stall--;
            end
            else
            begin
                tokens_bus.ready <= 1'b1;
                stall = pick_gap();
            end
        end
    end

    initial
    begin : stimulus
        logic [7:0]  text[$];
        logic [7:0]  sep;
        digit_base_e base;
        int          sent;
        int          form;
        int          n;
        int          r;
        string       marks;
        string       end_marks;
        tokens_sb = new();
        marks = "0123456789xXbBeE.+-_iuaZ";
        end_marks = " ,;)]+-*/\n\t";
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_data <= 8'd0;
        chars_bus.valid <= 1'b0;
        chars_bus.ch <= 8'd0;
        chars_bus.start_of_literal <= 1'b0;
        chars_bus.end_of_text <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            sep = (phase < PHASES - 1) ? SEP_PLAN[phase] : 8'($urandom_range(0, 255));
            cfg_write <= 1'b1;
            cfg_data <= sep;
            @(posedge clk);
            cfg_write <= 1'b0;
            tokens_sb.separator = sep;
            if (phase == 0)
            begin
                // ignored while idle, then an empty literal
                send_char("x", 1'b0, 1'b0);
                send_char(8'hff, 1'b1, 1'b1);
                send_word("0xf_Ai");
                send_char(" ", 1'b0, 1'b0);
                send_word(".5e-3");
                send_char(8'h00, 1'b0, 1'b1);
                // doubled separator, then dropped by the next start
                send_word("1__2");
                send_word("0b2");
                send_char(8'h00, 1'b0, 1'b0);
                send_word("z");
                send_char(8'hff, 1'b0, 1'b0);
            end
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 39) == 0)
                    no_gaps = !no_gaps;
                if ($urandom_range(0, 39) == 0)
                begin
                    send_char(8'($urandom_range(0, 255)), 1'b1, 1'b1);
                    sent++;
                end
                text.delete();
                n = ($urandom_range(0, 49) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 6);
                form = $urandom_range(0, 9);
                if (form < 4)
                begin
                    append_run(text, BASE_DEC, n + 1, sep);
                    if ($urandom_range(0, 2) == 0)
                    begin
                        text.push_back(".");
                        append_run(text, BASE_DEC, $urandom_range(0, 4), sep);
                    end
                    if ($urandom_range(0, 2) == 0)
                    begin
                        text.push_back($urandom_range(0, 1) ? "e" : "E");
                        if ($urandom_range(0, 1))
                            text.push_back($urandom_range(0, 1) ? "+" : "-");
                        append_run(text, BASE_DEC, $urandom_range(0, 4), sep);
                    end
                    if ($urandom_range(0, 4) == 0)
                        append_ident(text, $urandom_range(1, 3));
                end
                else if (form < 7)
                begin
                    base = $urandom_range(0, 1) ? BASE_HEX : BASE_BIN;
                    r = $urandom_range(0, 1);
                    text.push_back("0");
                    if (base == BASE_HEX)
                        text.push_back(r ? "x" : "X");
                    else
                        text.push_back(r ? "b" : "B");
                    append_run(text, base, n, sep);
                    r = $urandom_range(0, 5);
                    if (r == 0)
                        text.push_back($urandom_range(0, 1) ? "i" : "u");
                    if (r < 2)
                        append_ident(text, $urandom_range(0, 3));
                end
                else if (form == 7)
                begin
                    text.push_back(".");
                    append_run(text, BASE_DEC, n, sep);
                    if ($urandom_range(0, 1))
                    begin
                        text.push_back("e");
                        append_run(text, BASE_DEC, $urandom_range(0, 3), sep);
                    end
                end
                else if (form == 8)
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        if ($urandom_range(0, 5) == 0)
                            text.push_back(sep);
                        else
                            text.push_back(marks[$urandom_range(0, marks.len() - 1)]);
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, 4))
                        text.push_back(8'($urandom_range(0, 255)));
                end
                // broken sequence
                if ($urandom_range(0, 9) == 0)
                    text[$urandom_range(0, text.size() - 1)] = 8'($urandom_range(0, 255));
                for (int i = 0; i < text.size(); i++)
                    send_char(text[i], i == 0, 1'b0);
                sent += text.size();
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    if (r < 35)
                        send_char(end_marks[$urandom_range(0, end_marks.len() - 1)], 1'b0, 1'b0);
                    else
                        send_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    sent++;
                    if ($urandom_range(0, 9) == 0)
                        send_char(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
                end
                else if (r < 70)
                begin
                    send_char(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                    sent++;
                end
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
            end
        end
        wait_drained();
        repeat (8) @(posedge clk);
        if (tokens_sb.errors == 0 && tokens_sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
